### sv/gfmi_pkg.sv
package gfmi_pkg;

  localparam int MAX_DEGREE_DEF = 16;
  localparam int OP_W           = 2;
  localparam int OPERAND_W      = 16;
  localparam int DEG_W          = 5;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 5;
  localparam int MUL_STEPS      = 8;

  localparam logic [DEG_W-1:0] DEGREE_RST = 5'd4;
  localparam logic             MIDDLE_RST = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_FIELD_DEGREE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIDDLE_TERM  = 1'd1;

  typedef enum logic [OP_W-1:0] {
    OP_MUL  = 2'd0,
    OP_SQR  = 2'd1,
    OP_INV  = 2'd2,
    OP_NORM = 2'd3
  } op_e;

  typedef enum logic {
    SEL_PC = 1'b0,
    SEL_CC = 1'b1
  } sel_e;

  typedef struct packed {
    logic load;
    op_e  op;
    logic mul_start;
    sel_e mul_sel;
    logic wr_c;
    logic wr_p;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic             mul_done;
    logic [DEG_W-1:0] deg_m1;
  } status_t;

endpackage

### sv/gfmi_if.sv
interface gfmi_in_if import gfmi_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [OPERAND_W-1:0] operand_a;
  logic [OPERAND_W-1:0] operand_b;

  modport source (output valid, output operation, output operand_a, output operand_b,
                  input ready);
  modport sink (input valid, input operation, input operand_a, input operand_b,
                output ready);
endinterface

interface gfmi_out_if import gfmi_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OPERAND_W-1:0] result;

  modport source (output valid, output result, input ready);
  modport sink (input valid, input result, output ready);
endinterface

### sv/gfmi_mul.sv
module gfmi_mul import gfmi_pkg::*; #(
  parameter int EW = MAX_DEGREE_DEF,
  localparam int CW = $clog2(EW + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [EW-1:0] x_i,
  input  logic [EW-1:0] y_i,
  input  logic [CW-1:0] n_i,
  input  logic [EW-1:0] mask_i,
  input  logic [EW-1:0] top_i,
  input  logic          mid_i,
  output logic          done_o,
  output logic [EW-1:0] prod_o
);

  logic [EW-1:0] x_q, y_q, r_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [EW-1:0] step_v, step_y;
  logic          step_hi;

  // Horner steps, MSB of y first; up to MUL_STEPS bits per cycle
  always_comb begin
    step_v  = r_q;
    step_y  = y_q;
    step_hi = 1'b0;
    for (int k = 0; k < MUL_STEPS; k++) begin
      if (int'(cnt_q) > k) begin
        step_hi = |(step_v & top_i);
        step_v  = (step_v << 1) & mask_i;
        if (step_hi) begin
          step_v = step_v ^ EW'(1) ^ (mid_i ? top_i : '0);
        end
        if (step_y[EW-1]) begin
          step_v = step_v ^ x_q;
        end
        step_y = step_y << 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= n_i;
      end else if (busy_q) begin
        if (int'(cnt_q) > MUL_STEPS) begin
          cnt_q <= cnt_q - CW'(MUL_STEPS);
        end else begin
          cnt_q  <= '0;
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= x_i;
      y_q <= y_i << (CW'(EW) - n_i);
      r_q <= '0;
    end else if (busy_q) begin
      r_q <= step_v;
      y_q <= step_y;
    end
  end

  assign done_o = done_q;
  assign prod_o = r_q;

endmodule

### sv/gfmi_datapath.sv
module gfmi_datapath import gfmi_pkg::*; #(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [OPERAND_W-1:0] operand_a_i,
  input  logic [OPERAND_W-1:0] operand_b_i,
  input  cmd_t                 cmd_i,
  output status_t              status_o,
  output logic [OPERAND_W-1:0] result_o
);

  localparam int EW = MAX_DEGREE;
  localparam int CW = $clog2(EW + 1);

  logic [DEG_W-1:0]     degree_q;
  logic                 middle_q;
  logic [CW-1:0]        n_eff;
  logic [EW-1:0]        mask, top;
  logic [EW-1:0]        a_m, b_m;
  logic [EW-1:0]        c_q, p_q;
  logic [EW-1:0]        mul_x, mul_y, prod;
  logic                 mul_done;
  logic [OPERAND_W-1:0] res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= DEGREE_RST;
      middle_q <= MIDDLE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FIELD_DEGREE: degree_q <= cfg_data_i[DEG_W-1:0];
        REG_MIDDLE_TERM:  middle_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (int'(degree_q) < 2) begin
      n_eff = CW'(2);
    end else if (int'(degree_q) > MAX_DEGREE) begin
      n_eff = CW'(MAX_DEGREE);
    end else begin
      n_eff = CW'(degree_q);
    end
  end

  always_comb begin
    for (int i = 0; i < EW; i++) begin
      mask[i] = (i < int'(n_eff));
      top[i]  = (i == int'(n_eff) - 1);
      a_m[i]  = (i < OPERAND_W) ? operand_a_i[i] & mask[i] : 1'b0;
      b_m[i]  = (i < OPERAND_W) ? operand_b_i[i] & mask[i] : 1'b0;
    end
  end

  always_comb begin
    unique case (cmd_i.mul_sel)
      SEL_CC: begin
        mul_x = c_q;
        mul_y = c_q;
      end
      SEL_PC: begin
        mul_x = p_q;
        mul_y = c_q;
      end
      default: begin
        mul_x = p_q;
        mul_y = c_q;
      end
    endcase
  end

  gfmi_mul #(.EW(EW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .x_i     (mul_x),
    .y_i     (mul_y),
    .n_i     (n_eff),
    .mask_i  (mask),
    .top_i   (top),
    .mid_i   (middle_q),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      c_q <= a_m;
      case (cmd_i.op)
        OP_MUL:  p_q <= b_m;
        OP_INV:  p_q <= EW'(1);
        default: p_q <= a_m;
      endcase
    end else begin
      if (cmd_i.wr_c) c_q <= prod;
      if (cmd_i.wr_p) p_q <= prod;
    end
    if (cmd_i.out_load) begin
      for (int i = 0; i < OPERAND_W; i++) begin
        res_q[i] <= (i < EW) ? p_q[i] : 1'b0;
      end
    end
  end

  assign status_o.mul_done = mul_done;
  assign status_o.deg_m1   = DEG_W'(n_eff - CW'(1));
  assign result_o          = res_q;

endmodule

### sv/gfmi_ctrl.sv
module gfmi_ctrl import gfmi_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [OP_W-1:0] in_op_i,
  output logic            in_ready_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  input  status_t         status_i,
  output cmd_t            cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_START = 4'b0010,
    ST_WAIT  = 4'b0100,
    ST_PUSH  = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  op_e              op_q, op_d;
  logic             sq_q, sq_d;
  logic [DEG_W-1:0] iter_q, iter_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    sq_d        = sq_q;
    iter_d      = iter_q;
    cmd_o       = '0;
    cmd_o.op    = op_e'(in_op_i);
    cmd_o.mul_sel = sq_q ? SEL_CC : SEL_PC;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          op_d       = op_e'(in_op_i);
          sq_d       = (op_e'(in_op_i) != OP_MUL);
          iter_d     = status_i.deg_m1;
          state_d    = ST_START;
        end
      end
      ST_START: begin
        cmd_o.mul_start = 1'b1;
        state_d         = ST_WAIT;
      end
      ST_WAIT: begin
        if (status_i.mul_done) begin
          if (op_q == OP_MUL || op_q == OP_SQR) begin
            cmd_o.wr_p = 1'b1;
            state_d    = ST_PUSH;
          end else if (sq_q) begin
            cmd_o.wr_c = 1'b1;
            sq_d       = 1'b0;
            state_d    = ST_START;
          end else begin
            cmd_o.wr_p = 1'b1;
            sq_d       = 1'b1;
            iter_d     = iter_q - DEG_W'(1);
            state_d    = (iter_q == DEG_W'(1)) ? ST_PUSH : ST_START;
          end
        end
      end
      ST_PUSH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_MUL;
      sq_q        <= 1'b0;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      sq_q        <= sq_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### sv/gf2n_multiply_and_invert.sv
// One shared digit-serial field multiplier; each multiplication is issued, runs
// its multiplier pass and is written back to a working register.
// Multiply and square: a single multiplication before the result is output.
// Inverse and norm: 2*(n-1) multiplications, alternating square and multiply.
// The next input transaction is taken once the result sits in the output register.
// Reset (rst_ni low, asynchronous): idle, output empty, degree 4, middle term 1.
module gf2n_multiply_and_invert import gfmi_pkg::*; #(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  gfmi_in_if.sink               in_if,
  gfmi_out_if.source            out_if,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  gfmi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_op_i     (in_if.operation),
    .in_ready_o  (in_if.ready),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_if.valid),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  gfmi_datapath #(.MAX_DEGREE(MAX_DEGREE)) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .operand_a_i (in_if.operand_a),
    .operand_b_i (in_if.operand_b),
    .cmd_i       (cmd),
    .status_o    (status),
    .result_o    (out_if.result)
  );

endmodule
